### rtl/c2dvb_pkg.sv
// Shared constants and types for the 2D valid convolution block.
package c2dvb_pkg;

  // Default sizing of the line stores and the kernel window
  localparam int unsigned MAX_IMAGE_WIDTH_D   = 1024;
  localparam int unsigned MAX_KERNEL_HEIGHT_D = 8;
  localparam int unsigned MAX_KERNEL_WIDTH_D  = 8;

  // Field widths
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned KIDX_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IMG_W_W    = 11;
  localparam int unsigned IMG_H_W    = 16;
  localparam int unsigned KER_W      = 4;
  // Compare widths for image and kernel sizes over the full parameter range
  localparam int unsigned SZ_W       = 16;
  localparam int unsigned KSZ_W      = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_HEIGHT = 3'd2,
    CFG_KERNEL_WIDTH  = 3'd3,
    CFG_BIAS          = 3'd4
  } cfg_idx_t;

  // Input command codes
  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_PIXEL  = 1'b1;

  // Coordinates and frame mark that travel with a result
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } res_meta_t;

endpackage

### rtl/c2dvb_if.sv
// Valid/ready channel interfaces for the input items and the results.
interface c2dvb_in_if
  import c2dvb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [KIDX_W-1:0] kernel_row;
  logic [KIDX_W-1:0] kernel_col;
  logic [DATA_W-1:0] data;

  modport source (output valid, command, kernel_row, kernel_col, data, input ready);
  modport sink   (input valid, command, kernel_row, kernel_col, data, output ready);
endinterface

interface c2dvb_out_if
  import c2dvb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] conv_value;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              frame_last;

  modport source (output valid, conv_value, out_row, out_col, frame_last, input ready);
  modport sink   (input valid, conv_value, out_row, out_col, frame_last, output ready);
endinterface

### rtl/conv2d_valid_with_bias.sv
// Streaming valid 2D convolution with bias: line-store memory, window and adder tree.
//
// Channels: in_ch carries items; command 0 loads one kernel weight at
// (kernel_row, kernel_col), command 1 delivers the next pixel in raster
// order. out_ch carries one result per pixel that completes a kernel-sized
// window: the bias plus the window dot kernel modulo 2^64, its output row
// and column, and a mark on the last result of the frame. The user must
// write sizes and bias via cfg_ only while the block is idle (not enforced).
// Throughput: one item per cycle unless a stall lowers in_ch.ready. The
// previous rows of each column sit in one line-store memory row per column,
// read as each item is accepted and written back shifted; a pixel that hits
// the column just written takes the forwarded row.
// Path: a result passes from its accepted pixel through the stage 1 input
// register, the window stage, operand select, partial products, product
// merge, the registered adder tree and the bias add in the output register.
// Reset: sizes and bias return to defaults, counters and window clear, and a
// clearing pass zeroes the line store, one column per cycle, over all
// MAX_IMAGE_WIDTH columns; in_ch.ready stays low meanwhile.
// Stall: when out_ch.ready is low the pipeline fills up behind the output
// register and in_ch.ready drops only once no stage is free.
module conv2d_valid_with_bias
  import c2dvb_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_WIDTH   = MAX_IMAGE_WIDTH_D,
  parameter int unsigned MAX_KERNEL_HEIGHT = MAX_KERNEL_HEIGHT_D,
  parameter int unsigned MAX_KERNEL_WIDTH  = MAX_KERNEL_WIDTH_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  c2dvb_in_if.sink              in_ch,
  c2dvb_out_if.source           out_ch
);

  localparam int unsigned CW   = $clog2(MAX_IMAGE_WIDTH);
  localparam int unsigned NT   = MAX_KERNEL_HEIGHT * MAX_KERNEL_WIDTH;
  localparam int unsigned LV   = (NT > 1) ? $clog2(NT) : 0;
  localparam int unsigned NP   = 1 << LV;
  localparam int unsigned LN   = (MAX_KERNEL_HEIGHT > 1) ? MAX_KERNEL_HEIGHT - 1 : 1;
  localparam int unsigned KHI  = (MAX_KERNEL_HEIGHT > 1) ? $clog2(MAX_KERNEL_HEIGHT) : 1;
  localparam int unsigned KWI  = (MAX_KERNEL_WIDTH > 1) ? $clog2(MAX_KERNEL_WIDTH) : 1;
  localparam int unsigned LINE_W = LN * DATA_W;
  // Pipeline stage numbers
  localparam int unsigned ST_IN   = 1;
  localparam int unsigned ST_WIN  = 2;
  localparam int unsigned ST_OPS  = 3;
  localparam int unsigned ST_PP   = 4;
  localparam int unsigned ST_TREE = 5;
  localparam int unsigned LAST    = ST_TREE + LV + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [IMG_W_W-1:0]    img_w_r;
  logic [IMG_H_W-1:0]    img_h_r;
  logic [KER_W-1:0]      ker_h_r;
  logic [KER_W-1:0]      ker_w_r;
  logic [CFG_DATA_W-1:0] bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_W'(1024);
      img_h_r <= IMG_H_W'(1024);
      ker_h_r <= KER_W'(3);
      ker_w_r <= KER_W'(3);
      bias_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_IMAGE_WIDTH:   img_w_r <= cfg_data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:  img_h_r <= cfg_data[IMG_H_W-1:0];
        CFG_KERNEL_HEIGHT: ker_h_r <= cfg_data[KER_W-1:0];
        CFG_KERNEL_WIDTH:  ker_w_r <= cfg_data[KER_W-1:0];
        CFG_BIAS:          bias_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, oversize width and kernel sizes saturate
  logic [SZ_W-1:0]  w_ext, w_eff, h_eff;
  logic [KSZ_W-1:0] kh_ext, kw_ext, kh_eff, kw_eff;

  always_comb begin
    w_ext  = SZ_W'(img_w_r);
    kh_ext = KSZ_W'(ker_h_r);
    kw_ext = KSZ_W'(ker_w_r);
    if (w_ext == '0) w_eff = SZ_W'(1);
    else if (w_ext > SZ_W'(MAX_IMAGE_WIDTH)) w_eff = SZ_W'(MAX_IMAGE_WIDTH);
    else w_eff = w_ext;
    h_eff = (img_h_r == '0) ? SZ_W'(1) : SZ_W'(img_h_r);
    if (kh_ext == '0) kh_eff = KSZ_W'(1);
    else if (kh_ext > KSZ_W'(MAX_KERNEL_HEIGHT)) kh_eff = KSZ_W'(MAX_KERNEL_HEIGHT);
    else kh_eff = kh_ext;
    if (kw_ext == '0) kw_eff = KSZ_W'(1);
    else if (kw_ext > KSZ_W'(MAX_KERNEL_WIDTH)) kw_eff = KSZ_W'(MAX_KERNEL_WIDTH);
    else kw_eff = kw_ext;
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage is free when empty or when its content moves on
  logic [LAST:1] v_r;
  logic [LAST:1] free;
  logic          clr_r;
  logic          in_fire, in_pix;

  always_comb begin
    free[LAST] = !v_r[LAST] || out_ch.ready;
    for (int s = LAST - 1; s >= 1; s--) begin
      free[s] = !v_r[s] || free[s+1];
    end
  end

  assign in_ch.ready = free[ST_IN] && !clr_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_pix      = (in_ch.command == CMD_PIXEL);

  // ---------------------------------------------------------------------------
  // Pixel position and result decision
  logic [ROW_W-1:0] pix_row_r;
  logic [CW-1:0]    pix_col_r;
  logic [SZ_W-1:0]  col16;
  logic             row_end, frame_end, emit;
  res_meta_t        meta_in;

  always_comb begin
    col16     = SZ_W'(pix_col_r);
    row_end   = (col16 + SZ_W'(1)) >= w_eff;
    frame_end = row_end && (({1'b0, pix_row_r} + 17'd1) >= {1'b0, h_eff});
    emit      = (SZ_W'(kh_eff) <= h_eff) && (SZ_W'(kw_eff) <= w_eff)
             && (({1'b0, pix_row_r} + 17'd1) >= 17'(kh_eff))
             && ((col16 + SZ_W'(1)) >= SZ_W'(kw_eff));
    meta_in.row  = pix_row_r - (ROW_W'(kh_eff) - ROW_W'(1));
    meta_in.col  = COL_W'(col16 - (SZ_W'(kw_eff) - SZ_W'(1)));
    meta_in.last = frame_end;
  end

  // Advance the raster counters per accepted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_row_r <= '0;
      pix_col_r <= '0;
    end else if (in_fire && in_pix) begin
      if (frame_end) begin
        pix_row_r <= '0;
        pix_col_r <= '0;
      end else if (row_end) begin
        pix_row_r <= pix_row_r + ROW_W'(1);
        pix_col_r <= '0;
      end else begin
        pix_col_r <= pix_col_r + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: item held while the line-store row is read
  logic              s1_cmd_r;
  logic [KIDX_W-1:0] s1_kr_r, s1_kc_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [CW-1:0]     s1_addr_r;
  logic              s1_emit_r;
  res_meta_t         s1_meta_r;
  logic              s1_exit, s1_pix;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.command;
      s1_kr_r   <= in_ch.kernel_row;
      s1_kc_r   <= in_ch.kernel_col;
      s1_data_r <= in_ch.data;
      s1_addr_r <= pix_col_r;
      s1_emit_r <= in_pix && emit;
      s1_meta_r <= meta_in;
    end
  end

  assign s1_exit = v_r[ST_IN] && free[ST_WIN];
  assign s1_pix  = (s1_cmd_r == CMD_PIXEL);

  // ---------------------------------------------------------------------------
  // Line store: one row per column holding the previous image rows
  logic [LINE_W-1:0] line_mem [MAX_IMAGE_WIDTH];
  logic [LINE_W-1:0] rd_q_r, fwd_data_r, line_cur, line_new, mem_wdata;
  logic              fwd_r, mem_we;
  logic [CW-1:0]     mem_waddr, clr_cnt_r;

  // Take the row just written when the same column is read in that cycle
  assign line_cur = fwd_r ? fwd_data_r : rd_q_r;

  // Push the new pixel into the column, dropping the oldest row
  always_comb begin
    line_new = '0;
    line_new[DATA_W-1:0] = s1_data_r;
    for (int i = 1; i < LN; i++) begin
      line_new[i*DATA_W +: DATA_W] = line_cur[(i-1)*DATA_W +: DATA_W];
    end
  end

  assign mem_we    = clr_r || (s1_exit && s1_pix);
  assign mem_waddr = clr_r ? clr_cnt_r : s1_addr_r;
  assign mem_wdata = clr_r ? '0 : line_new;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_q_r <= line_mem[pix_col_r];
    end
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_fire) begin
      fwd_r <= s1_exit && s1_pix && (s1_addr_r == pix_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= line_new;
    end
  end

  // Zero the line store after reset, one column per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + CW'(1);
      if (clr_cnt_r == CW'(MAX_IMAGE_WIDTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window and kernel weights, updated in item order as stage 1 drains
  logic [DATA_W-1:0] win_r [MAX_KERNEL_HEIGHT][MAX_KERNEL_WIDTH];
  logic [DATA_W-1:0] wt_r  [MAX_KERNEL_HEIGHT][MAX_KERNEL_WIDTH];
  logic [DATA_W-1:0] col_in [MAX_KERNEL_HEIGHT];

  always_comb begin
    col_in[0] = s1_data_r;
    for (int i = 1; i < MAX_KERNEL_HEIGHT; i++) begin
      col_in[i] = line_cur[(i-1)*DATA_W +: DATA_W];
    end
  end

  // Shift the window one column and insert the new column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KERNEL_HEIGHT; i++) begin
        for (int j = 0; j < MAX_KERNEL_WIDTH; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_exit && s1_pix) begin
      for (int i = 0; i < MAX_KERNEL_HEIGHT; i++) begin
        for (int j = MAX_KERNEL_WIDTH - 1; j > 0; j--) begin
          win_r[i][j] <= win_r[i][j-1];
        end
        win_r[i][0] <= col_in[i];
      end
    end
  end

  // Load a weight; positions beyond the kernel maxima match no entry
  always_ff @(posedge clk) begin
    if (s1_exit && !s1_pix) begin
      for (int x = 0; x < MAX_KERNEL_HEIGHT; x++) begin
        for (int y = 0; y < MAX_KERNEL_WIDTH; y++) begin
          if ((32'(s1_kr_r) == x) && (32'(s1_kc_r) == y)) begin
            wt_r[x][y] <= s1_data_r;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 to 3: pick one window word and one weight per product lane
  logic [DATA_W-1:0] ops_a_nxt [NT];
  logic [DATA_W-1:0] ops_b_nxt [NT];
  logic [DATA_W-1:0] ops_a_r   [NT];
  logic [DATA_W-1:0] ops_b_r   [NT];

  always_comb begin
    logic [KSZ_W-1:0] hi, wi;
    for (int x = 0; x < MAX_KERNEL_HEIGHT; x++) begin
      for (int y = 0; y < MAX_KERNEL_WIDTH; y++) begin
        hi = kh_eff - KSZ_W'(x) - KSZ_W'(1);
        wi = kw_eff - KSZ_W'(y) - KSZ_W'(1);
        if ((KSZ_W'(x) < kh_eff) && (KSZ_W'(y) < kw_eff)) begin
          ops_a_nxt[x*MAX_KERNEL_WIDTH+y] = win_r[hi[KHI-1:0]][wi[KWI-1:0]];
        end else begin
          ops_a_nxt[x*MAX_KERNEL_WIDTH+y] = '0;
        end
        ops_b_nxt[x*MAX_KERNEL_WIDTH+y] = wt_r[x][y];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[ST_OPS]) begin
      ops_a_r <= ops_a_nxt;
      ops_b_r <= ops_b_nxt;
    end
  end

  // Stage 4: 32x32 partial products; only the low word of the cross terms counts
  logic [DATA_W-1:0] pp_ll_r [NT];
  logic [HALF_W-1:0] pp_lh_r [NT];
  logic [HALF_W-1:0] pp_hl_r [NT];

  always_ff @(posedge clk) begin
    if (free[ST_PP]) begin
      for (int l = 0; l < NT; l++) begin
        pp_ll_r[l] <= DATA_W'(ops_a_r[l][HALF_W-1:0]) * DATA_W'(ops_b_r[l][HALF_W-1:0]);
        pp_lh_r[l] <= HALF_W'(ops_a_r[l][HALF_W-1:0] * ops_b_r[l][DATA_W-1:HALF_W]);
        pp_hl_r[l] <= HALF_W'(ops_a_r[l][DATA_W-1:HALF_W] * ops_b_r[l][HALF_W-1:0]);
      end
    end
  end

  // Stage 5 onward: merge products, then a registered adder tree
  logic [DATA_W-1:0] tr_r [LV+1][NP];

  always_ff @(posedge clk) begin
    if (free[ST_TREE]) begin
      for (int k = 0; k < NP; k++) begin
        if (k < NT) begin
          tr_r[0][k] <= pp_ll_r[k] + {HALF_W'(pp_lh_r[k] + pp_hl_r[k]), HALF_W'(0)};
        end else begin
          tr_r[0][k] <= '0;
        end
      end
    end
  end

  for (genvar g = 0; g < LV; g++) begin : g_tree
    always_ff @(posedge clk) begin
      if (free[ST_TREE+g+1]) begin
        for (int k = 0; k < (NP >> (g + 1)); k++) begin
          tr_r[g+1][k] <= tr_r[g][2*k] + tr_r[g][2*k+1];
        end
      end
    end
  end

  // Output register: add the sign-extended bias
  logic [DATA_W-1:0] out_val_r;

  always_ff @(posedge clk) begin
    if (free[LAST]) begin
      out_val_r <= tr_r[LV][0] + {{(DATA_W-CFG_DATA_W){bias_r[CFG_DATA_W-1]}}, bias_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits and result coordinates along the pipeline
  res_meta_t meta_r [ST_WIN:LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (free[ST_IN]) begin
        v_r[ST_IN] <= in_fire;
      end
      // Drop weight loads and pixels without a result here
      if (free[ST_WIN]) begin
        v_r[ST_WIN] <= v_r[ST_IN] && s1_emit_r;
      end
      for (int s = ST_WIN + 1; s <= LAST; s++) begin
        if (free[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[ST_WIN]) begin
      meta_r[ST_WIN] <= s1_meta_r;
    end
    for (int s = ST_WIN + 1; s <= LAST; s++) begin
      if (free[s]) begin
        meta_r[s] <= meta_r[s-1];
      end
    end
  end

  assign out_ch.valid      = v_r[LAST];
  assign out_ch.conv_value = out_val_r;
  assign out_ch.out_row    = meta_r[LAST].row;
  assign out_ch.out_col    = meta_r[LAST].col;
  assign out_ch.frame_last = meta_r[LAST].last;

endmodule

### rtl/c2dvb_checker.sv
// Port-level checks for the convolution block, bound to the top level.
module c2dvb_checker
  import c2dvb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_value,
  input logic [ROW_W-1:0]  out_row,
  input logic [COL_W-1:0]  out_col,
  input logic              out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_row)
                                && $stable(out_col) && $stable(out_last))
    else $error("stalled result changed");

  // Line-store clearing blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("input taken during clearing pass");

endmodule

bind conv2d_valid_with_bias c2dvb_checker u_c2dvb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.conv_value),
  .out_row   (out_ch.out_row),
  .out_col   (out_ch.out_col),
  .out_last  (out_ch.frame_last)
);
